### rtl/rgblab_pkg.sv
// Shared types and constants for the RGB to CIE L*a*b* pixel unit.
// No dependencies.
package rgblab_pkg;

   localparam int FRAC_BITS_DEFAULT = 8;

   localparam int CH_W        = 8;
   localparam int W_W         = 24;
   localparam int T24_W       = 25;
   localparam int F_W         = 17;
   localparam int LLIN_W      = 17;
   localparam int CBRT_STAGES = 17;
   localparam int L_W         = 15;
   localparam int AB_W        = 16;

   localparam logic [T24_W-1:0] THRESH_Q24    = 25'd148579;
   localparam logic [18:0]      LIN_SLOPE_Q16 = 19'd510329;
   localparam logic [13:0]      LIN_OFF_Q16   = 14'd9039;
   localparam logic [25:0]      LIN_L_Q16     = 26'd59198669;
   localparam logic [31:0]      RECIP_255     = 32'h80808081;

   typedef logic [15:0] coef_type;
   typedef coef_type [2:0][2:0] matrix_type;

   // sRGB to XYZ, rows normalized by the D65 white point, Q16
   localparam matrix_type MAT_Q16 = '{
      '{16'd28440, 16'd24656, 16'd12441},
      '{16'd13938, 16'd46869, 16'd4730},
      '{16'd1164,  16'd7175,  16'd57198}
   };

   typedef struct packed {
      logic [CH_W-1:0] chan_first;
      logic [CH_W-1:0] chan_second;
      logic [CH_W-1:0] chan_third;
   } req_payload_type;

   typedef struct packed {
      logic [L_W-1:0]         lightness;
      logic signed [AB_W-1:0] green_red_axis;
      logic signed [AB_W-1:0] blue_yellow_axis;
   } rsp_payload_type;

   typedef struct packed {
      logic [2:0][F_W-1:0] flin;
      logic [2:0]          above;
      logic [LLIN_W-1:0]   llin;
   } side_type;

endpackage

### rtl/rgblab_cbrt_pipe.sv
// Pipelined floor cube root of t24 * 2^24, one result bit per stage.
// Depends on rgblab_pkg.
module rgblab_cbrt_pipe (
   input  logic                              clock,
   input  logic                              enable,
   input  logic [rgblab_pkg::T24_W-1:0]      t_in,
   output logic [rgblab_pkg::F_W-1:0]        root
);

   localparam int NS  = rgblab_pkg::CBRT_STAGES;
   localparam int RW  = 40;
   localparam int SW  = 34;
   localparam int RTW = rgblab_pkg::F_W;
   localparam int TPW = 27;

   logic [RW-1:0]  rem_ff [NS];
   logic [RTW-1:0] r_ff   [NS];
   logic [SW-1:0]  s_ff   [NS];
   logic [TPW-1:0] t_ff   [NS];

   for (genvar k = 0; k < NS; k++) begin : g_stage
      logic [RW-1:0]  rem_p;
      logic [RTW-1:0] r_p;
      logic [SW-1:0]  s_p;
      logic [TPW-1:0] t_p;
      logic [3*NS-1:0] nbits;
      logic [2:0]     grp;
      logic [RW-1:0]  rem3;
      logic [RW-1:0]  test;
      logic [RW-1:0]  rem_in;
      logic [RTW-1:0] r_in;
      logic [SW-1:0]  s_in;

      if (k == 0) begin : g_first
         assign rem_p = '0;
         assign r_p   = '0;
         assign s_p   = '0;
         assign t_p   = TPW'(t_in);
      end else begin : g_next
         assign rem_p = rem_ff[k-1];
         assign r_p   = r_ff[k-1];
         assign s_p   = s_ff[k-1];
         assign t_p   = t_ff[k-1];
      end

      assign nbits = {t_p, 24'd0};
      assign grp   = nbits[3*(NS-1-k) +: 3];

      always_comb begin
         rem3 = {rem_p[RW-4:0], grp};
         test = (RW'(s_p) << 3) + (RW'(s_p) << 2) + (RW'(r_p) << 2) + (RW'(r_p) << 1)
                + RW'(1);
         if (rem3 >= test) begin
            rem_in = rem3 - test;
            r_in   = {r_p[RTW-2:0], 1'b1};
            s_in   = (s_p << 2) + (SW'(r_p) << 2) + SW'(1);
         end else begin
            rem_in = rem3;
            r_in   = {r_p[RTW-2:0], 1'b0};
            s_in   = s_p << 2;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= rem_in;
            r_ff[k]   <= r_in;
            s_ff[k]   <= s_in;
            t_ff[k]   <= t_p;
         end
      end
   end

   assign root = r_ff[NS-1];

endmodule

### rtl/rgb_to_cielab_pixel_unit.sv
// Top level of the RGB to CIE L*a*b* (D65) pixel unit.
// Depends on rgblab_pkg and rgblab_cbrt_pipe.
//
// Usage:
//  - req channel (valid/ready) carries one 8-bit three-channel pixel per
//    transaction; rsp channel (valid/ready) returns L* unsigned and a*, b*
//    signed, in fixed point with FRAC_BITS fraction bits, saturated.
//  - csr_write_enable/csr_write_data set the channel order (0 = R,G,B;
//    1 = B,G,R); write only while the unit is empty.
//  - Pipeline from accept to rsp_valid: three stages for the matrix and
//    the divide by 255, 17 cube root stages (one root bit each), two
//    stages for the Lab arithmetic, rounding and saturation.
//  - Throughput: one transaction per cycle while the pipeline is not frozen.
//  - When rsp_ready is low with a result pending, the whole pipeline
//    freezes and req_ready drops; nothing is lost or repeated.
//  - Synchronous reset clears all valid bits and sets channel order to 0.
module rgb_to_cielab_pixel_unit #(
   parameter int FRAC_BITS = rgblab_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  rgblab_pkg::req_payload_type   req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rgblab_pkg::rsp_payload_type   rsp_data,
   input  logic                          csr_write_enable,
   input  logic                          csr_write_data
);

   localparam int NS    = rgblab_pkg::CBRT_STAGES;
   localparam int LAT   = NS + 5;
   localparam int SH    = 16 - FRAC_BITS;
   localparam int LSH   = 40 - FRAC_BITS;
   localparam int LMAXR = 100 << FRAC_BITS;
   localparam int LMAX  = (LMAXR > 32767) ? 32767 : LMAXR;
   localparam int T24_W = rgblab_pkg::T24_W;
   localparam int F_W   = rgblab_pkg::F_W;

   logic             order_ff;
   logic [LAT-1:0]   vld_ff;
   logic             enable;

   assign enable    = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = enable;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= 1'b0;
      end else if (csr_write_enable) begin
         order_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // stage 1: channel order and matrix
   logic [2:0][7:0]                     c;
   logic [2:0][rgblab_pkg::W_W-1:0]     w_in, w_ff;

   always_comb begin
      c[1] = req_data.chan_second;
      if (order_ff) begin
         c[0] = req_data.chan_third;
         c[2] = req_data.chan_first;
      end else begin
         c[0] = req_data.chan_first;
         c[2] = req_data.chan_third;
      end
      // matrix row 0, column 0 sits at the top packed index
      for (int i = 0; i < 3; i++) begin
         w_in[i] = rgblab_pkg::W_W'(24'(rgblab_pkg::MAT_Q16[2-i][2]) * 24'(c[0])
                 + 24'(rgblab_pkg::MAT_Q16[2-i][1]) * 24'(c[1])
                 + 24'(rgblab_pkg::MAT_Q16[2-i][0]) * 24'(c[2]));
      end
   end

   // stage 2: (W + 127) / 255 by reciprocal multiply
   logic [2:0][17:0]                    q_in, q_ff;
   logic [2:0][rgblab_pkg::W_W-1:0]     w2_ff;
   logic [2:0][56:0]                    prod;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod[i] = 57'(25'(w_ff[i]) + 25'd127) * 57'(rgblab_pkg::RECIP_255);
         q_in[i] = prod[i][56:39];
      end
   end

   // stage 3: t24 = W + (W + 127) / 255
   logic [2:0][T24_W-1:0] t_in, t_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         t_in[i] = T24_W'(w2_ff[i]) + T24_W'(q_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         w_ff  <= w_in;
         w2_ff <= w_ff;
         q_ff  <= q_in;
         t_ff  <= t_in;
      end
   end

   // cube roots and the linear branch in parallel
   logic [2:0][F_W-1:0]  root;

   for (genvar i = 0; i < 3; i++) begin : g_root
      rgblab_cbrt_pipe u_cbrt (
         .clock  (clock),
         .enable (enable),
         .t_in   (t_ff[i]),
         .root   (root[i])
      );
   end

   rgblab_pkg::side_type side_in;
   rgblab_pkg::side_type side_ff [NS];
   logic [2:0][36:0] lin_prod;
   logic [43:0]      l_prod;
   logic [44:0]      l_sum;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lin_prod[i] = 37'(t_ff[i][17:0]) * 37'(rgblab_pkg::LIN_SLOPE_Q16);
         side_in.flin[i] = F_W'((38'(lin_prod[i]) + (38'd1 << 23)) >> 24)
                         + F_W'(rgblab_pkg::LIN_OFF_Q16);
         side_in.above[i] = t_ff[i] > rgblab_pkg::THRESH_Q24;
      end
      l_prod = 44'(t_ff[1][17:0]) * 44'(rgblab_pkg::LIN_L_Q16);
      l_sum  = 45'(l_prod) + (45'd1 << (LSH - 1));
      side_in.llin = rgblab_pkg::LLIN_W'(l_sum >> LSH);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < NS; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // stage A: select f, scale differences
   logic signed [17:0]      f [3];
   logic signed [31:0]      dl_in, da_in, db_in, dl_ff, da_ff, db_ff;
   logic                    ya_ff;
   logic [rgblab_pkg::LLIN_W-1:0] llin_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         f[i] = side_ff[NS-1].above[i] ? $signed({1'b0, root[i]})
                                       : $signed({1'b0, side_ff[NS-1].flin[i]});
      end
      dl_in = 32'(f[1]) * 32'sd116 - 32'sd1048576;
      da_in = 32'(f[0] - f[1]) * 32'sd500;
      db_in = 32'(f[1] - f[2]) * 32'sd200;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dl_ff   <= dl_in;
         da_ff   <= da_in;
         db_ff   <= db_in;
         ya_ff   <= side_ff[NS-1].above[1];
         llin_ff <= side_ff[NS-1].llin;
      end
   end

   // stage B: select L*, round, saturate
   function automatic logic signed [31:0] round_shift(input logic signed [31:0] v);
      logic [31:0] m;
      logic [31:0] half;
      half = 32'd1 << (SH - 1);
      if (v < 0) begin
         m = 32'(-v);
         return -$signed((m + half) >> SH);
      end
      return $signed((32'(v) + half) >> SH);
   endfunction

   logic signed [31:0]          lr, ar, br;
   rgblab_pkg::rsp_payload_type out_in, out_ff;

   always_comb begin
      lr = ya_ff ? round_shift(dl_ff) : $signed(32'(llin_ff));
      ar = round_shift(da_ff);
      br = round_shift(db_ff);
      if (lr < 0) begin
         out_in.lightness = '0;
      end else if (lr > LMAX) begin
         out_in.lightness = rgblab_pkg::L_W'(LMAX);
      end else begin
         out_in.lightness = lr[rgblab_pkg::L_W-1:0];
      end
      if (ar < -32768) begin
         out_in.green_red_axis = 16'sh8000;
      end else if (ar > 32767) begin
         out_in.green_red_axis = 16'sh7fff;
      end else begin
         out_in.green_red_axis = ar[15:0];
      end
      if (br < -32768) begin
         out_in.blue_yellow_axis = 16'sh8000;
      end else if (br > 32767) begin
         out_in.blue_yellow_axis = 16'sh7fff;
      end else begin
         out_in.blue_yellow_axis = br[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_ff <= out_in;
      end
   end

   assign rsp_data = out_ff;

endmodule
